>>> sv/lsvs_pkg.sv
// ----------------------------------------------------------------------------
// lsvs_pkg
// Shared types and constants for the LRU stack victim select unit.
// ----------------------------------------------------------------------------
package lsvs_pkg;

    localparam int NUM_BUFFERS = 64;
    localparam int ID_W        = 6;
    localparam int ADDR_W      = $clog2(NUM_BUFFERS);

    // request kind codes as they arrive on the input item
    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_VICTIM = 2'd2;
    localparam logic [1:0] KIND_PIN    = 2'd3;

    typedef logic [ID_W-1:0] id_t;

    typedef struct packed {
        logic [1:0] kind;
        id_t        buffer_index;
        logic       pin_flag;
    } req_t;

    typedef struct packed {
        id_t  victim_index;
        logic status;
    } rsp_t;

    // decoded operation broadcast to the cell chain
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ACCESS = 3'd1,
        OP_DELETE = 3'd2,
        OP_VICTIM = 3'd3,
        OP_PIN    = 3'd4
    } op_t;

    typedef struct packed {
        op_t  op;
        id_t  id;
        logic flag;
    } cmd_t;

    // one stack position: buffer id, occupancy, copy of that buffer's pin bit
    typedef struct packed {
        id_t  id;
        logic valid;
        logic pin;
    } entry_t;

    localparam entry_t ENTRY_EMPTY = '{id: '0, valid: 1'b0, pin: 1'b0};

endpackage

>>> sv/lru_stack_victim_select_unit.sv
// ----------------------------------------------------------------------------
// lru_stack_victim_select_unit
// Recency stack of buffer ids with pin-aware victim selection.
// ----------------------------------------------------------------------------
// For each item, the accept cycle first latches the request and reads
// the buffer's pin bit from the pin RAM, and the execute cycle lets the row of
// stack cells match, pick and shift in one step. A victim request returns one
// result item (id of the least recent unpinned buffer on the stack, or status
// 1 when there is none); the other kinds return nothing. The execute cycle of
// a victim request waits while an earlier result is still held and stalled.
// The pin RAM needs no clearing pass: a row of written flags makes unwritten
// entries read as unpinned.
module lru_stack_victim_select_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  lsvs_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output lsvs_pkg::rsp_t  rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                             state_reg, state_next;
    lsvs_pkg::op_t                      op_reg, op_next;
    lsvs_pkg::id_t                      id_reg;
    logic                               flag_reg;
    logic                               front_known_reg;
    logic [lsvs_pkg::NUM_BUFFERS-1:0]   pin_wr_reg;
    logic                               rsp_valid_reg;
    lsvs_pkg::rsp_t                     rsp_reg;

    logic                               accept;
    logic                               advance;
    logic                               in_range;
    logic [lsvs_pkg::ADDR_W-1:0]        req_addr;
    logic [lsvs_pkg::ADDR_W-1:0]        exec_addr;
    logic                               pin_rd;
    logic                               pin_wr_en;
    lsvs_pkg::cmd_t                     cmd;
    lsvs_pkg::entry_t                   front_ent;

    lsvs_pkg::entry_t                   ent   [lsvs_pkg::NUM_BUFFERS];
    logic                               seen  [lsvs_pkg::NUM_BUFFERS+1];
    logic                               found [lsvs_pkg::NUM_BUFFERS+1];
    lsvs_pkg::id_t                      vid   [lsvs_pkg::NUM_BUFFERS+1];

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);
    assign advance   = (state_reg == ST_EXEC) &&
                       ((op_reg != lsvs_pkg::OP_VICTIM) || !rsp_valid_reg || !rsp_stall);
    assign in_range  = (32'(req.buffer_index) < lsvs_pkg::NUM_BUFFERS);
    assign req_addr  = lsvs_pkg::ADDR_W'(req.buffer_index);
    assign exec_addr = lsvs_pkg::ADDR_W'(id_reg);
    assign pin_wr_en = advance && (op_reg == lsvs_pkg::OP_PIN);

    always_comb
    begin
        case (req.kind)
            lsvs_pkg::KIND_ACCESS: op_next = in_range ? lsvs_pkg::OP_ACCESS : lsvs_pkg::OP_NONE;
            lsvs_pkg::KIND_DELETE: op_next = in_range ? lsvs_pkg::OP_DELETE : lsvs_pkg::OP_NONE;
            lsvs_pkg::KIND_VICTIM: op_next = lsvs_pkg::OP_VICTIM;
            lsvs_pkg::KIND_PIN:    op_next = in_range ? lsvs_pkg::OP_PIN : lsvs_pkg::OP_NONE;
            default:               op_next = lsvs_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= lsvs_pkg::OP_NONE;
            pin_wr_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                op_reg <= op_next;
            end
            if (pin_wr_en)
            begin
                pin_wr_reg[exec_addr] <= 1'b1;
            end
            if (advance && (op_reg == lsvs_pkg::OP_VICTIM))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg          <= req.buffer_index;
            flag_reg        <= req.pin_flag;
            front_known_reg <= pin_wr_reg[req_addr];
        end
        if (advance && (op_reg == lsvs_pkg::OP_VICTIM))
        begin
            rsp_reg.victim_index <= vid[0];
            rsp_reg.status       <= !found[0];
        end
    end

    lsvs_ram #(
        .WIDTH (1),
        .DEPTH (lsvs_pkg::NUM_BUFFERS)
    ) u_pin_ram (
        .clk     (clk),
        .wr_en   (pin_wr_en),
        .wr_addr (exec_addr),
        .wr_data (flag_reg),
        .rd_en   (accept),
        .rd_addr (req_addr),
        .rd_data (pin_rd)
    );

    // hold the chain still unless the item completes this cycle
    assign cmd.op   = advance ? op_reg : lsvs_pkg::OP_NONE;
    assign cmd.id   = id_reg;
    assign cmd.flag = flag_reg;

    always_comb
    begin
        if (op_reg == lsvs_pkg::OP_VICTIM)
        begin
            front_ent = '{id: vid[0], valid: 1'b1, pin: 1'b0};
        end
        else
        begin
            front_ent = '{id: id_reg, valid: 1'b1, pin: pin_rd && front_known_reg};
        end
    end

    assign seen[0]                     = 1'b0;
    assign found[lsvs_pkg::NUM_BUFFERS] = 1'b0;
    assign vid[lsvs_pkg::NUM_BUFFERS]   = '0;

    for (genvar i = 0; i < lsvs_pkg::NUM_BUFFERS; i++)
    begin : g_cell
        lsvs_pkg::entry_t upper_ent;
        lsvs_pkg::entry_t lower_ent;

        if (i == 0)
        begin : g_head
            assign upper_ent = front_ent;
        end
        else
        begin : g_body
            assign upper_ent = ent[i-1];
        end

        if (i == lsvs_pkg::NUM_BUFFERS-1)
        begin : g_tail
            assign lower_ent = lsvs_pkg::ENTRY_EMPTY;
        end
        else
        begin : g_inner
            assign lower_ent = ent[i+1];
        end

        lsvs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .upper_ent (upper_ent),
            .lower_ent (lower_ent),
            .seen_in   (seen[i]),
            .seen_out  (seen[i+1]),
            .found_in  (found[i+1]),
            .vid_in    (vid[i+1]),
            .found_out (found[i]),
            .vid_out   (vid[i]),
            .ent       (ent[i])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> sv/lsvs_ram.sv
// ----------------------------------------------------------------------------
// lsvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsvs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/lsvs_cell.sv
// ----------------------------------------------------------------------------
// lsvs_cell
// One position of the recency stack. Matches the broadcast id, takes part in
// the hit prefix chain (toward deeper cells) and the victim chain (toward
// cell 0), and shifts its entry to or from a neighbor.
// ----------------------------------------------------------------------------
module lsvs_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lsvs_pkg::cmd_t       cmd,
    input  lsvs_pkg::entry_t     upper_ent,   // more recent neighbor
    input  lsvs_pkg::entry_t     lower_ent,   // less recent neighbor
    input  logic                 seen_in,     // hit in a more recent cell
    output logic                 seen_out,
    input  logic                 found_in,    // candidate in a less recent cell
    input  lsvs_pkg::id_t        vid_in,
    output logic                 found_out,
    output lsvs_pkg::id_t        vid_out,
    output lsvs_pkg::entry_t     ent
);

    lsvs_pkg::entry_t ent_reg;
    lsvs_pkg::entry_t ent_next;
    logic             match;
    logic             cand;

    assign match     = ent_reg.valid && (ent_reg.id == cmd.id);
    assign cand      = ent_reg.valid && !ent_reg.pin;
    assign seen_out  = seen_in || match;
    assign found_out = found_in || cand;
    // the deepest unpinned entry wins
    assign vid_out   = found_in ? vid_in : (cand ? ent_reg.id : '0);

    always_comb
    begin
        ent_next = ent_reg;
        case (cmd.op)
            lsvs_pkg::OP_ACCESS:
            begin
                // push down everything above the hit, or the whole run on a miss
                if (!seen_in && upper_ent.valid)
                begin
                    ent_next = upper_ent;
                end
            end
            lsvs_pkg::OP_VICTIM:
            begin
                if (found_in || cand)
                begin
                    ent_next = upper_ent;
                end
            end
            lsvs_pkg::OP_DELETE:
            begin
                // close the gap from the hit downward
                if (seen_in || match)
                begin
                    ent_next = lower_ent;
                end
            end
            lsvs_pkg::OP_PIN:
            begin
                if (match)
                begin
                    ent_next.pin = cmd.flag;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= lsvs_pkg::ENTRY_EMPTY;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

>>> sv/lsvs_checker.sv
// ----------------------------------------------------------------------------
// lsvs_checker
// Port-level checks for the LRU stack victim select unit.
// ----------------------------------------------------------------------------
module lsvs_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input lsvs_pkg::req_t  req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input lsvs_pkg::rsp_t  rsp
);

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("input accepted while previous item still executing");

    // only victim requests produce a result item
    a_no_result_for_update: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req.kind != lsvs_pkg::KIND_VICTIM))
        |=> ##1 !$rose(rsp_valid))
        else $error("result item produced for a non-victim request");

    // a new result follows an executing item
    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result item appeared without an executing item");

    // no victim found carries a zero index
    a_none_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (rsp.victim_index == '0))
        else $error("none-available result with nonzero index");

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result item changed");

endmodule

bind lru_stack_victim_select_unit lsvs_checker u_lsvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU stack victim select unit. A short table of
// directed requests is replayed first, then about 650 random requests in
// three load phases. An in-bench recency stack predicts every victim
// result; each result is checked against the oldest typed or predicted one.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 217;
    localparam int NUM_ROWS         = 25;

    // directed row: request, whether the result is typed in, typed result
    typedef struct packed {
        lsvs_pkg::req_t item;
        logic           typed;
        lsvs_pkg::rsp_t want;
    } row_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           rsp_stall = 1'b0;
    lsvs_pkg::req_t req       = '0;
    logic           req_stall;
    logic           rsp_valid;
    lsvs_pkg::rsp_t rsp;

    // predicted recency stack: entry 0 is most recent
    lsvs_pkg::id_t  stack_ids [lsvs_pkg::NUM_BUFFERS];
    int             stack_depth = 0;
    bit             pin_bits [lsvs_pkg::NUM_BUFFERS];
    lsvs_pkg::rsp_t pending_victims [$];

    int             mismatches = 0;
    int             send_idle  = 7;
    int             stall_pct  = 68;
    lsvs_pkg::rsp_t want_rsp;

    // layout: kind, buffer_index, pin_flag, typed, victim_index, status
    row_t directed_rows [NUM_ROWS] = '{
        {lsvs_pkg::KIND_VICTIM, 6'd0,  1'b0, 1'b1, 6'd0,  1'b1},  // empty after reset
        {lsvs_pkg::KIND_DELETE, 6'd5,  1'b0, 1'b0, 6'd0,  1'b0},  // delete of absent id
        {lsvs_pkg::KIND_PIN,    6'd63, 1'b1, 1'b0, 6'd0,  1'b0},  // pin an id off the stack
        {lsvs_pkg::KIND_ACCESS, 6'd0,  1'b0, 1'b0, 6'd0,  1'b0},  // insert into empty stack
        {lsvs_pkg::KIND_ACCESS, 6'd63, 1'b0, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_VICTIM, 6'd63, 1'b1, 1'b1, 6'd0,  1'b0},  // skip pinned 63
        {lsvs_pkg::KIND_PIN,    6'd0,  1'b1, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_VICTIM, 6'd0,  1'b0, 1'b1, 6'd0,  1'b1},  // all pinned
        {lsvs_pkg::KIND_PIN,    6'd63, 1'b0, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_VICTIM, 6'd0,  1'b0, 1'b1, 6'd63, 1'b0},
        {lsvs_pkg::KIND_ACCESS, 6'd0,  1'b1, 1'b0, 6'd0,  1'b0},  // hit, move to front
        {lsvs_pkg::KIND_ACCESS, 6'd42, 1'b0, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_ACCESS, 6'd21, 1'b0, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_PIN,    6'd21, 1'b1, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_VICTIM, 6'd0,  1'b0, 1'b1, 6'd63, 1'b0},
        {lsvs_pkg::KIND_VICTIM, 6'd17, 1'b1, 1'b0, 6'd0,  1'b0},  // scan past pinned tail
        {lsvs_pkg::KIND_DELETE, 6'd42, 1'b0, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_DELETE, 6'd42, 1'b1, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_DELETE, 6'd63, 1'b0, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_DELETE, 6'd21, 1'b0, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_DELETE, 6'd0,  1'b0, 1'b0, 6'd0,  1'b0},  // stack empty again
        {lsvs_pkg::KIND_VICTIM, 6'd0,  1'b0, 1'b1, 6'd0,  1'b1},
        {lsvs_pkg::KIND_PIN,    6'd0,  1'b0, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_ACCESS, 6'd0,  1'b0, 1'b0, 6'd0,  1'b0},
        {lsvs_pkg::KIND_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0,  1'b0}
    };

    lru_stack_victim_select_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int locate(lsvs_pkg::id_t id);
        int pos;
        pos = -1;
        for (int i = 0; i < stack_depth; i++)
            if (stack_ids[i] == id)
                pos = i;
        return pos;
    endfunction

    function automatic void move_to_front(int pos);
        lsvs_pkg::id_t keep;
        keep = stack_ids[pos];
        for (int i = pos; i > 0; i--)
            stack_ids[i] = stack_ids[i-1];
        stack_ids[0] = keep;
    endfunction

    // advance the predicted stack by one request; report a victim result
    function automatic void update_recency_stack(input lsvs_pkg::req_t r, output bit gives,
                                                 output lsvs_pkg::rsp_t pick);
        int pos;
        gives = 1'b0;
        pick  = '0;
        pos   = -1;
        case (r.kind)
            lsvs_pkg::KIND_VICTIM:
            begin
                gives       = 1'b1;
                pick.status = 1'b1;
                // last hit in the upward walk is the least recent unpinned id
                for (int i = 0; i < stack_depth; i++)
                    if (!pin_bits[stack_ids[i]])
                        pos = i;
                if (pos >= 0)
                begin
                    pick.victim_index = stack_ids[pos];
                    pick.status       = 1'b0;
                    move_to_front(pos);
                end
            end
            lsvs_pkg::KIND_ACCESS:
            begin
                pos = locate(r.buffer_index);
                if (pos >= 0)
                    move_to_front(pos);
                else if (stack_depth < lsvs_pkg::NUM_BUFFERS)
                begin
                    for (int i = stack_depth; i > 0; i--)
                        stack_ids[i] = stack_ids[i-1];
                    stack_ids[0] = r.buffer_index;
                    stack_depth++;
                end
            end
            lsvs_pkg::KIND_DELETE:
            begin
                pos = locate(r.buffer_index);
                if (pos >= 0)
                begin
                    for (int i = pos; i < stack_depth - 1; i++)
                        stack_ids[i] = stack_ids[i+1];
                    stack_depth--;
                end
            end
            default:
                pin_bits[r.buffer_index] = r.pin_flag;
        endcase
    endfunction

    function automatic lsvs_pkg::req_t random_item(int phase);
        lsvs_pkg::req_t r;
        int             roll;
        int             access_w;
        int             reuse_pct;
        access_w         = (phase == 0) ? 55 : 35;
        roll             = $urandom_range(99);
        r.buffer_index   = lsvs_pkg::id_t'($urandom_range(lsvs_pkg::NUM_BUFFERS - 1));
        r.pin_flag       = 1'($urandom_range(1));
        if (roll < access_w)
            r.kind = lsvs_pkg::KIND_ACCESS;
        else if (roll < access_w + 15)
            r.kind = lsvs_pkg::KIND_DELETE;
        else if (roll < access_w + 40)
            r.kind = lsvs_pkg::KIND_VICTIM;
        else
            r.kind = lsvs_pkg::KIND_PIN;
        // aim most requests at ids already on the stack
        reuse_pct = (r.kind == lsvs_pkg::KIND_ACCESS) ? 40 : 70;
        if (stack_depth > 0 && $urandom_range(99) < reuse_pct)
            r.buffer_index = stack_ids[$urandom_range(stack_depth - 1)];
        // pin heavily late on so victim scans run deep
        if (r.kind == lsvs_pkg::KIND_PIN && phase == 2)
            r.pin_flag = ($urandom_range(99) < 75);
        return r;
    endfunction

    task automatic send_one(input lsvs_pkg::req_t r, output bit gives,
                            output lsvs_pkg::rsp_t pick);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        update_recency_stack(r, gives, pick);
    endtask

    // drop valid for a random gap now and then
    task automatic idle_gap();
        if ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    task automatic flag_mismatch(input string what, input lsvs_pkg::rsp_t want,
                                 input lsvs_pkg::rsp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR %0t: %s: expected id %0d status %0d, got id %0d status %0d",
                     $realtime, what, want.victim_index, want.status,
                     got.victim_index, got.status);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_victims.size() == 0)
                flag_mismatch("result with none pending", '0, rsp);
            else
            begin
                want_rsp = pending_victims.pop_front();
                if (rsp.victim_index !== want_rsp.victim_index ||
                    rsp.status !== want_rsp.status)
                    flag_mismatch("victim result", want_rsp, rsp);
            end
        end
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        bit             gives;
        lsvs_pkg::rsp_t pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            send_one(directed_rows[k].item, gives, pick);
            if (gives)
                pending_victims.push_back(directed_rows[k].typed ?
                                          directed_rows[k].want : pick);
            idle_gap();
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 7;
                    stall_pct = 68;
                end
                1:
                begin
                    send_idle = 68;
                    stall_pct = 7;
                end
                default:
                begin
                    send_idle = 0;
                    stall_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
            begin
                send_one(random_item(phase), gives, pick);
                if (gives)
                    pending_victims.push_back(pick);
                idle_gap();
            end
        end
        req_valid <= 1'b0;

        while (pending_victims.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0 && pending_victims.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
sv/lsvs_pkg.sv
sv/lsvs_ram.sv
sv/lsvs_cell.sv
sv/lru_stack_victim_select_unit.sv
sv/lsvs_checker.sv
tb/tb.sv
